/* src/lyap_pkg.sv */
// Shared types and constants for the logistic-map Lyapunov exponent block.
// Used by lyap_ctrl, lyap_dpath and lyapunov_exponent_pixel; depends on nothing.
`default_nettype none
package lyap_pkg;

  // Default parameter values.
  localparam int DEF_MAX_PATTERN   = 32;
  localparam int DEF_WARMUP_STEPS  = 100;
  localparam int DEF_AVERAGE_STEPS = 200;

  // Fixed-point constants.
  localparam int          FRAC_BITS  = 24;
  localparam int          NORM_STEPS = 6;
  localparam logic [63:0] FLOOR_Q62  = 64'd461168602;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [31:0] HALF_Q32   = 32'h8000_0000;
  localparam logic [29:0] ESC_VALUE  = 30'(1 << FRAC_BITS);

  // Quotient correction steps after the reciprocal estimate.
  localparam int DIV_FIX_STEPS = 4;

  // Configuration register indexes.
  localparam logic REG_PATTERN_BITS   = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_X,
    ST_CHECK,
    ST_NORM_LOAD,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_UPD,
    ST_LN_MUL,
    ST_LN_ACC,
    ST_DIV_LOAD,
    ST_DIV_MUL,
    ST_DIV_BACK,
    ST_DIV_REM,
    ST_DIV_FIX,
    ST_DONE_OK,
    ST_DONE_ESC
  } lyap_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_MUL_P,
    OP_MUL_X,
    OP_CHECK,
    OP_NORM_LOAD,
    OP_NORM_STEP,
    OP_SQ_MUL,
    OP_SQ_UPD,
    OP_LN_MUL,
    OP_LN_ACC,
    OP_DIV_LOAD,
    OP_DIV_MUL,
    OP_DIV_BACK,
    OP_DIV_REM,
    OP_DIV_FIX,
    OP_FINISH_OK,
    OP_FINISH_ESC
  } lyap_op_t;

  typedef struct packed {
    lyap_op_t   op;
    logic       avg;    // current step is in the averaging phase
    logic       first;  // first squaring iteration
    logic [2:0] sub;    // normalize step index
  } lyap_cmd_t;

  typedef struct packed {
    logic escape;       // x left the open unit interval on this step
  } lyap_stat_t;

endpackage
`default_nettype wire

/* src/lyap_ctrl.sv */
// Controller state machine for the Lyapunov exponent block.
// Depends on lyap_pkg; drives lyap_dpath through command and status structs.
`default_nettype none
module lyap_ctrl import lyap_pkg::*; #(
  parameter int WARMUP_STEPS  = DEF_WARMUP_STEPS,
  parameter int AVERAGE_STEPS = DEF_AVERAGE_STEPS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  output lyap_cmd_t       cmd,
  input  wire lyap_stat_t stat
);

  localparam int TOTAL  = WARMUP_STEPS + AVERAGE_STEPS;
  localparam int STEP_W = $clog2(TOTAL + 1);
  localparam int CNT_W  = $clog2(FRAC_BITS + NORM_STEPS + DIV_FIX_STEPS + 1);

  lyap_state_t        state, state_next;
  logic [STEP_W-1:0]  step_cnt;
  logic [CNT_W-1:0]   sub_cnt;
  logic               avg, last_step;

  assign avg       = step_cnt >= STEP_W'(WARMUP_STEPS);
  assign last_step = step_cnt == STEP_W'(TOTAL - 1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (start) state_next = ST_MUL_P;
      ST_MUL_P:     state_next = ST_MUL_X;
      ST_MUL_X:     state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.escape) state_next = ST_DONE_ESC;
        else if (avg) state_next = ST_NORM_LOAD;
        else state_next = ST_MUL_P;
      end
      ST_NORM_LOAD: state_next = ST_NORM;
      ST_NORM:      if (sub_cnt == CNT_W'(NORM_STEPS - 1)) state_next = ST_SQ_MUL;
      ST_SQ_MUL:    state_next = ST_SQ_UPD;
      ST_SQ_UPD: begin
        if (sub_cnt == CNT_W'(FRAC_BITS - 1)) state_next = ST_LN_MUL;
        else state_next = ST_SQ_MUL;
      end
      ST_LN_MUL:    state_next = ST_LN_ACC;
      ST_LN_ACC:    state_next = last_step ? ST_DIV_LOAD : ST_MUL_P;
      ST_DIV_LOAD:  state_next = ST_DIV_MUL;
      ST_DIV_MUL:   state_next = ST_DIV_BACK;
      ST_DIV_BACK:  state_next = ST_DIV_REM;
      ST_DIV_REM:   state_next = ST_DIV_FIX;
      ST_DIV_FIX:   if (sub_cnt == CNT_W'(DIV_FIX_STEPS - 1)) state_next = ST_DONE_OK;
      ST_DONE_OK:   state_next = ST_IDLE;
      ST_DONE_ESC:  state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      sub_cnt  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE:      step_cnt <= '0;
        ST_CHECK:     if (!avg) step_cnt <= step_cnt + 1'b1;
        ST_LN_ACC:    step_cnt <= step_cnt + 1'b1;
        ST_NORM_LOAD: sub_cnt <= '0;
        ST_NORM: begin
          if (sub_cnt == CNT_W'(NORM_STEPS - 1)) sub_cnt <= '0;
          else sub_cnt <= sub_cnt + 1'b1;
        end
        ST_SQ_UPD:    sub_cnt <= sub_cnt + 1'b1;
        ST_DIV_LOAD:  sub_cnt <= '0;
        ST_DIV_FIX:   sub_cnt <= sub_cnt + 1'b1;
        default:      ;
      endcase
    end
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.avg   = avg;
    cmd.first = (sub_cnt == '0);
    cmd.sub   = sub_cnt[2:0];
    case (state)
      ST_IDLE:      cmd.op = start ? OP_INIT : OP_NONE;
      ST_MUL_P:     cmd.op = OP_MUL_P;
      ST_MUL_X:     cmd.op = OP_MUL_X;
      ST_CHECK:     cmd.op = OP_CHECK;
      ST_NORM_LOAD: cmd.op = OP_NORM_LOAD;
      ST_NORM:      cmd.op = OP_NORM_STEP;
      ST_SQ_MUL:    cmd.op = OP_SQ_MUL;
      ST_SQ_UPD:    cmd.op = OP_SQ_UPD;
      ST_LN_MUL:    cmd.op = OP_LN_MUL;
      ST_LN_ACC:    cmd.op = OP_LN_ACC;
      ST_DIV_LOAD:  cmd.op = OP_DIV_LOAD;
      ST_DIV_MUL:   cmd.op = OP_DIV_MUL;
      ST_DIV_BACK:  cmd.op = OP_DIV_BACK;
      ST_DIV_REM:   cmd.op = OP_DIV_REM;
      ST_DIV_FIX:   cmd.op = OP_DIV_FIX;
      ST_DONE_OK:   cmd.op = OP_FINISH_OK;
      ST_DONE_ESC:  cmd.op = OP_FINISH_ESC;
      default:      cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // An escape always ends the word with the escape result.
  a_escape_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && stat.escape) |=> state == ST_DONE_ESC)
    else $error("escape did not end the word");

  // The step counter stays inside the iteration range while working.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step_cnt <= STEP_W'(TOTAL))
    else $error("step counter out of range");

  // An accepted start always begins with the first map multiply.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_MUL_P && step_cnt == '0))
    else $error("start not taken");

endmodule
`default_nettype wire

/* src/lyap_dpath.sv */
// Datapath for the Lyapunov exponent block: map state, shared multiplier,
// log2 normalizer and squarer, accumulator and divider. Depends on lyap_pkg.
`default_nettype none
module lyap_dpath import lyap_pkg::*; #(
  parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
  parameter int AVERAGE_STEPS = DEF_AVERAGE_STEPS,
  parameter int SUM_W         = 32 + $clog2(AVERAGE_STEPS + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lyap_cmd_t   cmd,
  output lyap_stat_t       stat,
  input  wire logic [31:0] rate_a,
  input  wire logic [31:0] rate_b,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic [29:0]      exponent,
  output logic             left_range,
  output logic             done
);

  localparam int POS_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // Reciprocal of the step count, scaled so that it fills 32 bits.
  localparam int DIV_L   = $clog2(AVERAGE_STEPS);
  localparam int DIV_T   = SUM_W - 33;
  localparam int DIV_QSH = 31 + DIV_L - DIV_T;
  localparam logic [31:0] RECIP     = 32'((64'd1 << (31 + DIV_L)) / 64'(AVERAGE_STEPS));
  localparam logic [31:0] DIV_MUL_K = 32'(AVERAGE_STEPS);
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(AVERAGE_STEPS);

  logic [31:0]       pattern_bits;
  logic [5:0]        pattern_length;
  logic [31:0]       ra, rb, x, y;
  logic [POS_W-1:0]  pos;
  logic [63:0]       prod, v;
  logic [5:0]        k;
  logic [FRAC_BITS-1:0] frac;
  logic              ln_neg, div_neg;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]  num;
  logic [31:0]       quo;
  logic [SUM_W-1:0]  rem;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= 32'd1;
      pattern_length <= 6'd2;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PATTERN_BITS) pattern_bits <= cfg_data;
      else pattern_length <= cfg_data[5:0];
    end
  end

  // Rate selection from the wrapping pattern.
  logic [6:0] len_eff, pos_ext, pos_inc;
  logic [31:0] r;
  always_comb begin
    if (pattern_length == 6'd0) len_eff = 7'd1;
    else if ({1'b0, pattern_length} > 7'(MAX_PATTERN)) len_eff = 7'(MAX_PATTERN);
    else len_eff = {1'b0, pattern_length};
    pos_ext = 7'(pos);
    pos_inc = pos_ext + 7'd1;
    r = (pos_ext < 7'd32 && pattern_bits[pos_ext[4:0]]) ? ra : rb;
  end

  // Derivative magnitude |1 - 2x| from the current x.
  logic [32:0] twox, m33;
  always_comb begin
    twox = {x, 1'b0};
    m33  = twox[32] ? (twox - 33'h1_0000_0000) : (33'h1_0000_0000 - twox);
  end

  // Log2 value and its magnitude for the ln2 scaling.
  logic signed [31:0] kk, l2;
  logic [31:0] l2_mag;
  always_comb begin
    kk     = $signed({26'd0, k}) - 32'sd62;
    l2     = (kk <<< FRAC_BITS) + $signed({{(32-FRAC_BITS){1'b0}}, frac});
    l2_mag = l2[31] ? (32'd0 - 32'(l2)) : 32'(l2);
  end

  // Divider by the step count: reciprocal estimate, back multiply and a few
  // compare and subtract corrections on the magnitude of the sum.
  logic [31:0] num_top, q_est, q_signed;
  logic        ge;
  always_comb begin
    num_top  = 32'(num >> DIV_T);
    q_est    = 32'(prod >> DIV_QSH);
    ge       = rem >= DIVISOR;
    q_signed = div_neg ? (32'd0 - quo) : quo;
  end

  // Shared multiplier operand selection.
  logic [31:0] mul_a, mul_b, ysrc;
  logic        mul_en;
  always_comb begin
    ysrc   = cmd.first ? v[63:32] : y;
    mul_en = 1'b1;
    mul_a  = x;
    mul_b  = 32'd0 - x;
    case (cmd.op)
      OP_MUL_P:    begin mul_a = x;       mul_b = 32'd0 - x;    end
      OP_MUL_X:    begin mul_a = r;       mul_b = prod[63:32];  end
      OP_CHECK:    begin mul_a = r;       mul_b = m33[31:0];    end
      OP_SQ_MUL:   begin mul_a = ysrc;    mul_b = ysrc;         end
      OP_LN_MUL:   begin mul_a = l2_mag;  mul_b = LN2_Q32;      end
      OP_DIV_MUL:  begin mul_a = num_top; mul_b = RECIP;        end
      OP_DIV_BACK: begin mul_a = q_est;   mul_b = DIV_MUL_K;    end
      default:     mul_en = 1'b0;
    endcase
  end

  assign stat.escape = (prod[63:30] == 34'd0) || (prod[63:62] != 2'd0);

  // Normalize step: test the top w bits and shift them out when zero.
  logic [63:0] v_sh;
  logic [5:0]  k_sh;
  logic        top_zero;
  always_comb begin
    case (cmd.sub)
      3'd0:    begin top_zero = v[63:32] == '0; v_sh = v << 32; k_sh = k - 6'd32; end
      3'd1:    begin top_zero = v[63:48] == '0; v_sh = v << 16; k_sh = k - 6'd16; end
      3'd2:    begin top_zero = v[63:56] == '0; v_sh = v << 8;  k_sh = k - 6'd8;  end
      3'd3:    begin top_zero = v[63:60] == '0; v_sh = v << 4;  k_sh = k - 6'd4;  end
      3'd4:    begin top_zero = v[63:62] == '0; v_sh = v << 2;  k_sh = k - 6'd2;  end
      default: begin top_zero = !v[63];         v_sh = v << 1;  k_sh = k - 6'd1;  end
    endcase
  end

  logic signed [SUM_W-1:0] ln_ext;
  assign ln_ext = SUM_W'($signed({1'b0, prod[63:32]}));

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (mul_en) prod <= 64'(mul_a) * 64'(mul_b);
    case (cmd.op)
      OP_INIT: begin
        ra  <= rate_a;
        rb  <= rate_b;
        x   <= HALF_Q32;
        pos <= '0;
        sum <= '0;
      end
      OP_CHECK: begin
        x <= prod[61:30];
        if (pos_inc >= len_eff) pos <= '0;
        else pos <= pos_inc[POS_W-1:0];
      end
      OP_NORM_LOAD: begin
        v    <= (prod < FLOOR_Q62) ? FLOOR_Q62 : prod;
        k    <= 6'd63;
        frac <= '0;
      end
      OP_NORM_STEP: begin
        if (top_zero) begin
          v <= v_sh;
          k <= k_sh;
        end
      end
      OP_SQ_UPD: begin
        frac <= {frac[FRAC_BITS-2:0], prod[63]};
        y    <= prod[63] ? prod[63:32] : prod[62:31];
      end
      OP_LN_MUL: ln_neg <= l2[31];
      OP_LN_ACC: sum <= ln_neg ? (sum - ln_ext) : (sum + ln_ext);
      OP_DIV_LOAD: begin
        div_neg <= sum[SUM_W-1];
        num     <= sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum)) : SUM_W'(sum);
      end
      OP_DIV_BACK: quo <= q_est;
      OP_DIV_REM:  rem <= num - SUM_W'(prod);
      OP_DIV_FIX: begin
        if (ge) begin
          rem <= rem - DIVISOR;
          quo <= quo + 32'd1;
        end
      end
      OP_FINISH_OK: begin
        exponent   <= q_signed[29:0];
        left_range <= 1'b0;
      end
      OP_FINISH_ESC: begin
        exponent   <= ESC_VALUE;
        left_range <= 1'b1;
      end
      default: ;
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (cmd.op == OP_FINISH_OK) || (cmd.op == OP_FINISH_ESC);
  end

endmodule
`default_nettype wire

/* src/lyapunov_exponent_pixel.sv */
// Lyapunov exponent of the logistic map for one pixel, top level.
// A new word is accepted only while idle, one word at a time, and ends early with the
// escape result when x escapes. The log2 squaring loop of each averaging step runs on
// the single shared 32x32 multiplier. Results are strobed one cycle on done; the
// receiver cannot stall. Synchronous reset clears control and config.
`default_nettype none
module lyapunov_exponent_pixel import lyap_pkg::*; #(
  parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
  parameter int WARMUP_STEPS  = DEF_WARMUP_STEPS,
  parameter int AVERAGE_STEPS = DEF_AVERAGE_STEPS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] rate_a,
  input  wire logic [31:0] rate_b,
  output logic             done,
  output logic [29:0]      exponent,
  output logic             left_range,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int SUM_W = 32 + $clog2(AVERAGE_STEPS + 1);

  lyap_cmd_t  cmd;
  lyap_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  lyap_ctrl #(
    .WARMUP_STEPS (WARMUP_STEPS),
    .AVERAGE_STEPS(AVERAGE_STEPS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .stat (stat)
  );

  lyap_dpath #(
    .MAX_PATTERN  (MAX_PATTERN),
    .AVERAGE_STEPS(AVERAGE_STEPS),
    .SUM_W        (SUM_W)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .rate_a    (rate_a),
    .rate_b    (rate_b),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .exponent  (exponent),
    .left_range(left_range),
    .done      (done)
  );

endmodule
`default_nettype wire
